// ===== hw/rtl/sic_pkg.sv =====
// Shared types and constants for the slider intervalometer controller.
package sic_pkg;

	localparam int unsigned EXPO_W = 16;
	localparam int unsigned WAKE_W = 8;
	localparam int unsigned TPS_W = 10;
	localparam int unsigned CFG_IDX_W = 2;
	localparam int unsigned CFG_DATA_W = 16;
	localparam int unsigned VAL_W = 10;
	localparam int unsigned SEC_W = 8;
	localparam int unsigned TMR_W = 16;
	localparam int unsigned QUEUE_DEPTH = 2;

	localparam logic [CFG_IDX_W-1:0] CFG_EXPOSURE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_WAKE = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_TPS = 2'd2;

	typedef enum logic [1:0] {
		BTN_PREV = 2'd0,
		BTN_DEC = 2'd1,
		BTN_INC = 2'd2,
		BTN_NEXT = 2'd3
	} button_t;

	typedef enum logic [1:0] {
		MENU_COUNT = 2'd0,
		MENU_INTERVAL = 2'd1,
		MENU_MOVE = 2'd2,
		MENU_SHOOT = 2'd3
	} menu_t;

	typedef enum logic [2:0] {
		PH_IDLE = 3'd0,
		PH_WAKE = 3'd1,
		PH_GAP = 3'd2,
		PH_FOCUS = 3'd3,
		PH_SHUT = 3'd4,
		PH_SETTLE = 3'd5,
		PH_MOTOR = 3'd6,
		PH_WAIT = 3'd7
	} phase_t;

	typedef enum logic [2:0] {
		EX_IDLE,
		EX_APPLY,
		EX_MOD,
		EX_DISP,
		EX_HMS,
		EX_OUT
	} exec_state_t;

	typedef struct packed {
		logic is_tick;
		logic new_second;
		button_t button;
	} cmd_t;

	typedef struct packed {
		logic focus_on;
		logic shutter_on;
		logic motor_on;
		logic [1:0] menu_position;
		logic [9:0] shot_target;
		logic [9:0] interval_s;
		logic [9:0] move_ms;
		logic [9:0] shots_done;
		logic [4:0] left_hours;
		logic [5:0] left_minutes;
		logic [5:0] left_seconds;
		logic [9:0] next_shot_in;
	} result_t;

endpackage

// ===== hw/rtl/sic_front.sv =====
// Front end: accepts beats, keeps the millisecond counter and marks second boundaries.
module sic_front (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic                            in_mode,
	input  logic [1:0]                      in_button,
	input  logic [sic_pkg::TPS_W-1:0]       tps,
	input  logic                            q_full,
	output logic                            q_push,
	output sic_pkg::cmd_t                   q_cmd
);
	import sic_pkg::*;

	logic [TPS_W-1:0] ms_q;
	logic [TPS_W-1:0] ms_inc;
	logic wrap;

	assign in_stall = q_full;
	assign q_push = in_valid && !q_full;
	assign ms_inc = ms_q + 1'b1;
	assign wrap = (ms_inc >= tps) || (ms_inc == '0);

	always_comb begin
		q_cmd.is_tick = !in_mode;
		q_cmd.new_second = !in_mode && wrap;
		q_cmd.button = button_t'(in_button);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ms_q <= '0;
		end else if (q_push && !in_mode) begin
			ms_q <= wrap ? '0 : ms_inc;
		end
	end

endmodule

// ===== hw/rtl/sic_queue.sv =====
// Short command queue between the front end and the executor.
module sic_queue #(
	parameter int unsigned DEPTH = sic_pkg::QUEUE_DEPTH
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  sic_pkg::cmd_t push_cmd,
	output logic          full,
	input  logic          pop,
	output logic          not_empty,
	output sic_pkg::cmd_t head_cmd
);
	import sic_pkg::*;

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	cmd_t slot_q [DEPTH];
	logic [PTR_W-1:0] wr_q;
	logic [PTR_W-1:0] rd_q;
	logic [PTR_W:0] cnt_q;

	assign full = (cnt_q == (PTR_W+1)'(DEPTH));
	assign not_empty = (cnt_q != '0);
	assign head_cmd = slot_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PTR_W'(DEPTH-1)) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == PTR_W'(DEPTH-1)) ? '0 : rd_q + 1'b1;
			end
			cnt_q <= cnt_q + (PTR_W+1)'(push) - (PTR_W+1)'(pop);
		end
	end

`ifndef SYNTH
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> !push) else $error("queue overflow");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> not_empty) else $error("queue underflow");
	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> cnt_q == $past(cnt_q) + 1'b1) else $error("count slip");
`endif

endmodule

// ===== hw/rtl/sic_exec.sv =====
// Back end: menu, shot sequencer, remaining-time arithmetic and result register.
module sic_exec (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            q_valid,
	input  sic_pkg::cmd_t                   q_cmd,
	output logic                            q_pop,
	input  logic [sic_pkg::EXPO_W-1:0]      exposure,
	input  logic [sic_pkg::WAKE_W-1:0]      wake_thr,
	output logic                            out_valid,
	input  logic                            out_stall,
	output sic_pkg::result_t                res
);
	import sic_pkg::*;

	exec_state_t st_q, st_d;
	menu_t menu_q;
	logic [VAL_W-1:0] target_q, interval_q, move_q, taken_q, countdown_q;
	logic [SEC_W-1:0] sec_q;
	phase_t phase_q;
	logic [TMR_W-1:0] timer_q;
	logic [4:0] hrs_q;
	logic [5:0] min_q, secs_q;
	cmd_t cmd_q;
	logic [SEC_W-1:0] rem_q;
	logic [VAL_W-1:0] div_q;
	logic [15:0] secs_acc_q;
	logic [15:0] prod_a_q, prod_b_q;
	logic res_valid_q;
	result_t res_q;

	logic [VAL_W-1:0] iv;
	logic mod_done;
	logic [5:0] min_quot;
	logic [5:0] sec_rest;

	function automatic logic [TMR_W-1:0] plen(phase_t ph, logic [EXPO_W-1:0] ex,
			logic [VAL_W-1:0] mv);
		unique case (ph)
			PH_WAKE: plen = TMR_W'(50);
			PH_GAP: plen = TMR_W'(100);
			PH_FOCUS: plen = TMR_W'(50);
			PH_SHUT: plen = ex;
			PH_SETTLE: plen = TMR_W'(200);
			PH_MOTOR: plen = TMR_W'(mv);
			PH_WAIT: plen = TMR_W'(1000);
			default: plen = '0;
		endcase
	endfunction

	assign iv = (interval_q == '0) ? VAL_W'(1) : interval_q;
	assign q_pop = (st_q == EX_IDLE) && q_valid;
	assign out_valid = res_valid_q;
	assign res = res_q;
	assign mod_done = (rem_q < SEC_W'(div_q)) || (div_q > VAL_W'(255));
	assign min_quot = 6'(({12'd0, secs_acc_q[11:0]} * 24'd4370) >> 18);
	assign sec_rest = secs_acc_q[5:0] - min_quot * 6'd60;

	always_comb begin
		st_d = st_q;
		unique case (st_q)
			EX_IDLE: if (q_valid) st_d = EX_APPLY;
			EX_APPLY: st_d = cmd_q.is_tick ? EX_MOD : EX_OUT;
			EX_MOD: if (mod_done) st_d = cmd_q.new_second ? EX_DISP : EX_OUT;
			EX_DISP: st_d = EX_HMS;
			EX_HMS: if (secs_acc_q < 16'd3600) st_d = EX_OUT;
			EX_OUT: if (!res_valid_q || !out_stall) st_d = EX_IDLE;
			default: st_d = EX_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= EX_IDLE;
		end else begin
			st_q <= st_d;
		end
	end

	// Sequencer step: advance phases, skipping zero-length ones (at most eight).
	phase_t ph_n;
	logic [TMR_W-1:0] tm_n;
	logic [VAL_W-1:0] tk_n;
	logic [SEC_W-1:0] sc_n;
	always_comb begin
		phase_t p;
		logic [TMR_W-1:0] t;
		logic go;
		ph_n = phase_q;
		tm_n = timer_q;
		tk_n = taken_q;
		sc_n = cmd_q.new_second ? sec_q + 1'b1 : sec_q;
		go = 1'b0;
		p = PH_IDLE;
		t = '0;
		if (phase_q != PH_IDLE) begin
			tm_n = timer_q - 1'b1;
			if (tm_n == '0) begin
				go = 1'b1;
				p = (phase_q == PH_WAIT) ? PH_IDLE : phase_t'(phase_q + 1'b1);
			end
		end
		for (int k = 0; k < 8; k++) begin
			if (go) begin
				if (p == PH_IDLE) begin
					ph_n = PH_IDLE;
					tm_n = '0;
					go = 1'b0;
				end else begin
					if (p == PH_WAIT) tk_n = tk_n + 1'b1;
					t = plen(p, exposure, move_q);
					tm_n = t;
					if (t != '0) begin
						ph_n = p;
						go = 1'b0;
					end else begin
						p = (p == PH_WAIT) ? PH_IDLE : phase_t'(p + 1'b1);
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			menu_q <= MENU_COUNT;
			target_q <= VAL_W'(60);
			interval_q <= VAL_W'(20);
			move_q <= VAL_W'(300);
			taken_q <= '0;
			sec_q <= '0;
			phase_q <= PH_IDLE;
			timer_q <= '0;
			hrs_q <= '0;
			min_q <= '0;
			secs_q <= '0;
			countdown_q <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (st_q == EX_APPLY) begin
				if (cmd_q.is_tick) begin
					sec_q <= sc_n;
					phase_q <= ph_n;
					timer_q <= tm_n;
					taken_q <= tk_n;
				end else if (phase_q == PH_IDLE) begin
					unique case (cmd_q.button)
						BTN_PREV: if (menu_q != MENU_COUNT) menu_q <= menu_t'(menu_q - 1'b1);
						BTN_DEC: begin
							if (menu_q == MENU_COUNT && target_q > 10'd1) begin
								if (target_q > 10'd60) target_q <= target_q - 10'd30;
								else if (target_q > 10'd20) target_q <= target_q - 10'd10;
								else target_q <= target_q - 10'd1;
							end else if (menu_q == MENU_INTERVAL && interval_q > 10'd2) begin
								if (interval_q > 10'd60) interval_q <= interval_q - 10'd10;
								else if (interval_q > 10'd20) interval_q <= interval_q - 10'd5;
								else interval_q <= interval_q - 10'd1;
							end else if (menu_q == MENU_MOVE && move_q > 10'd300) begin
								move_q <= move_q - 10'd100;
							end
						end
						BTN_INC: begin
							if (menu_q == MENU_COUNT && target_q < 10'd969) begin
								if (target_q >= 10'd60) target_q <= target_q + 10'd30;
								else if (target_q >= 10'd20) target_q <= target_q + 10'd10;
								else target_q <= target_q + 10'd1;
							end else if (menu_q == MENU_INTERVAL && interval_q < 10'd989) begin
								if (interval_q >= 10'd60) interval_q <= interval_q + 10'd10;
								else if (interval_q >= 10'd20) interval_q <= interval_q + 10'd5;
								else interval_q <= interval_q + 10'd1;
							end else if (menu_q == MENU_MOVE && move_q < 10'd900) begin
								move_q <= move_q + 10'd100;
							end
						end
						BTN_NEXT: begin
							if (menu_q != MENU_SHOOT) begin
								menu_q <= menu_t'(menu_q + 1'b1);
								if (menu_q == MENU_MOVE) sec_q <= '0;
							end
						end
						default: ;
					endcase
				end
			end
			// Start test needs seconds mod interval; run it after the mod loop on every tick.
			if (st_q == EX_MOD && mod_done && cmd_q.is_tick) begin
				if (phase_q == PH_IDLE && menu_q == MENU_SHOOT && taken_q < target_q &&
					(div_q > VAL_W'(255) ? sec_q == '0 : rem_q == '0)) begin
					phase_q <= (interval_q > VAL_W'(wake_thr)) ? PH_WAKE : PH_FOCUS;
					timer_q <= TMR_W'(50);
				end
				if (cmd_q.new_second && menu_q == MENU_SHOOT && taken_q < target_q) begin
					countdown_q <= iv - (div_q > VAL_W'(255) ? VAL_W'(sec_q) : VAL_W'(rem_q));
				end
			end
			if (st_q == EX_HMS && st_d == EX_OUT) begin
				min_q <= min_quot;
				secs_q <= sec_rest;
			end
			if (st_q == EX_DISP) begin
				hrs_q <= '0;
			end else if (st_q == EX_HMS && secs_acc_q >= 16'd3600) begin
				hrs_q <= hrs_q + 1'b1;
			end
			if (st_q == EX_OUT && (!res_valid_q || !out_stall)) begin
				res_valid_q <= 1'b1;
			end else if (res_valid_q && !out_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	// Datapath registers without reset.
	logic [15:0] base_sum;
	assign base_sum = prod_a_q - ((menu_q == MENU_SHOOT && taken_q < target_q) ?
		(prod_b_q - 16'(iv - (div_q > VAL_W'(255) ? VAL_W'(sec_q) : VAL_W'(rem_q))))
		: 16'd0);

	always_ff @(posedge clk) begin
		if (q_pop) begin
			cmd_q <= q_cmd;
		end
		if (st_q == EX_APPLY) begin
			// seconds counter after this beat
			rem_q <= cmd_q.is_tick ? sc_n : sec_q;
			div_q <= iv;
			prod_a_q <= 16'(target_q - 1'b1) * 16'(interval_q);
			prod_b_q <= 16'(tk_n) * 16'(interval_q);
		end else if (st_q == EX_MOD && !mod_done) begin
			rem_q <= rem_q - SEC_W'(div_q);
		end
		if (st_q == EX_DISP) begin
			secs_acc_q <= base_sum;
		end else if (st_q == EX_HMS && secs_acc_q >= 16'd3600) begin
			secs_acc_q <= secs_acc_q - 16'd3600;
		end
		if (st_q == EX_OUT && (!res_valid_q || !out_stall)) begin
			res_q.focus_on <= (phase_q == PH_WAKE || phase_q == PH_FOCUS ||
				phase_q == PH_SHUT);
			res_q.shutter_on <= (phase_q == PH_SHUT);
			res_q.motor_on <= (phase_q == PH_MOTOR);
			res_q.menu_position <= menu_q;
			res_q.shot_target <= target_q;
			res_q.interval_s <= interval_q;
			res_q.move_ms <= move_q;
			res_q.shots_done <= taken_q;
			res_q.left_hours <= hrs_q;
			res_q.left_minutes <= min_q;
			res_q.left_seconds <= secs_q;
			res_q.next_shot_in <= countdown_q;
		end
	end

`ifndef SYNTH
	a_pop_idle: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |=> st_q == EX_APPLY) else $error("pop outside idle");
	a_shut_focus: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && res_q.shutter_on |-> res_q.focus_on) else $error("shutter without focus");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && out_stall |=> res_valid_q) else $error("result dropped");
`endif

endmodule

// ===== hw/rtl/slider_intervalometer_controller.sv =====
// Top level of the slider intervalometer controller.
// A press passes the idle, apply and output states; a tick adds the seconds-modulo loop,
// and a second boundary adds the display step and the hours loop after it.
// The executor takes a new beat only after the last one has left the output state;
// a stalled result holds the executor.
// Reset: asynchronous, active low; settings return to 60 shots, 20 s, 300 ms.
module slider_intervalometer_controller (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic                          mode,
	input  logic [1:0]                    button,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic                          focus_on,
	output logic                          shutter_on,
	output logic                          motor_on,
	output logic [1:0]                    menu_position,
	output logic [9:0]                    shot_target,
	output logic [9:0]                    interval_s,
	output logic [9:0]                    move_ms,
	output logic [9:0]                    shots_done,
	output logic [4:0]                    left_hours,
	output logic [5:0]                    left_minutes,
	output logic [5:0]                    left_seconds,
	output logic [9:0]                    next_shot_in,
	input  logic                          cfg_we,
	input  logic [sic_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [sic_pkg::CFG_DATA_W-1:0] cfg_data
);
	import sic_pkg::*;

	logic [EXPO_W-1:0] expo_q;
	logic [WAKE_W-1:0] wake_q;
	logic [TPS_W-1:0] tps_q;
	logic q_full, q_push, q_ne, q_pop;
	cmd_t push_cmd, head_cmd;
	result_t res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expo_q <= EXPO_W'(100);
			wake_q <= WAKE_W'(60);
			tps_q <= TPS_W'(1000);
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_EXPOSURE: expo_q <= cfg_data;
				CFG_WAKE: wake_q <= cfg_data[WAKE_W-1:0];
				CFG_TPS: tps_q <= cfg_data[TPS_W-1:0];
				default: ;
			endcase
		end
	end

	sic_front u_front (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.in_mode(mode), .in_button(button), .tps(tps_q), .q_full(q_full),
		.q_push(q_push), .q_cmd(push_cmd)
	);

	sic_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
		.clk(clk), .arst_n(arst_n), .push(q_push), .push_cmd(push_cmd),
		.full(q_full), .pop(q_pop), .not_empty(q_ne), .head_cmd(head_cmd)
	);

	sic_exec u_exec (
		.clk(clk), .arst_n(arst_n), .q_valid(q_ne), .q_cmd(head_cmd), .q_pop(q_pop),
		.exposure(expo_q), .wake_thr(wake_q), .out_valid(out_valid),
		.out_stall(out_stall), .res(res)
	);

	assign focus_on = res.focus_on;
	assign shutter_on = res.shutter_on;
	assign motor_on = res.motor_on;
	assign menu_position = res.menu_position;
	assign shot_target = res.shot_target;
	assign interval_s = res.interval_s;
	assign move_ms = res.move_ms;
	assign shots_done = res.shots_done;
	assign left_hours = res.left_hours;
	assign left_minutes = res.left_minutes;
	assign left_seconds = res.left_seconds;
	assign next_shot_in = res.next_shot_in;

endmodule

// ===== verif/tb_slider_intervalometer_controller.sv =====
// Self-checking testbench for the slider intervalometer controller: menu, sequencer and display.
module tb_slider_intervalometer_controller;
	timeunit 1ns;
	timeprecision 1ps;
	import sic_pkg::*;

	typedef struct {
		bit m;
		button_t b;
		bit chk;
		menu_t menu;
		int unsigned tgt;
		int unsigned ivl;
		int unsigned mv;
	} stim_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic mode = 1'b0;
	logic [1:0] button = 2'd0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic focus_on, shutter_on, motor_on;
	logic [1:0] menu_position;
	logic [9:0] shot_target, interval_s, move_ms, shots_done, next_shot_in;
	logic [4:0] left_hours;
	logic [5:0] left_minutes, left_seconds;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = CFG_EXPOSURE;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	result_t exp_q[$];
	int errs = 0;
	bit calm = 1'b0;
	bit hold_req = 1'b0;

	// predictor state
	int unsigned expo, wake_thr, tps;
	int unsigned menu, tgt, ivl, mv, taken, msc, secc, ptmr, hms, cdown;
	phase_t ph;

	always #5 clk = ~clk;

	slider_intervalometer_controller u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .mode(mode), .button(button),
		.out_valid(out_valid), .out_stall(out_stall),
		.focus_on(focus_on), .shutter_on(shutter_on), .motor_on(motor_on),
		.menu_position(menu_position), .shot_target(shot_target),
		.interval_s(interval_s), .move_ms(move_ms), .shots_done(shots_done),
		.left_hours(left_hours), .left_minutes(left_minutes),
		.left_seconds(left_seconds), .next_shot_in(next_shot_in),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	function automatic int unsigned phase_len(int unsigned p);
		case (p)
			PH_WAKE: return 50;
			PH_GAP: return 100;
			PH_FOCUS: return 50;
			PH_SHUT: return expo & 'hFFFF;
			PH_SETTLE: return 200;
			PH_MOTOR: return mv & 'hFFFF;
			PH_WAIT: return 1000;
			default: return 0;
		endcase
	endfunction

	function automatic int unsigned sec_mod();
		int unsigned d;
		d = ivl ? ivl : 1;
		return secc % d;
	endfunction

	function automatic void enter_phase(int unsigned p);
		while (p != PH_IDLE) begin
			if (p == PH_WAIT)
				taken = (taken + 1) & 'h3FF;
			ptmr = phase_len(p);
			if (ptmr != 0) begin
				ph = phase_t'(p);
				return;
			end
			p = (p >= PH_WAIT) ? PH_IDLE : p + 1;
		end
		ph = PH_IDLE;
		ptmr = 0;
	endfunction

	function automatic void refresh_display();
		int unsigned iv, secs, r, sub, h, t;
		iv = ivl ? ivl : 1;
		secs = ((tgt - 1) * ivl) & 'hFFFF;
		if (menu == MENU_SHOOT && taken < tgt) begin
			r = sec_mod();
			sub = (taken * ivl - (iv - r)) & 'hFFFF;
			secs = (secs - sub) & 'hFFFF;
			cdown = (iv - r) & 'h3FF;
		end
		h = secs / 3600;
		t = secs % 3600;
		hms = ((h & 'h1F) << 12) | ((t / 60) << 6) | (t % 60);
	endfunction

	function automatic void apply_press(button_t b);
		case (b)
			BTN_PREV: if (menu > MENU_COUNT) menu--;
			BTN_DEC: begin
				if (menu == MENU_COUNT && tgt > 1) begin
					if (tgt > 60) tgt -= 30;
					else if (tgt > 20) tgt -= 10;
					else tgt--;
				end else if (menu == MENU_INTERVAL && ivl > 2) begin
					if (ivl > 60) ivl -= 10;
					else if (ivl > 20) ivl -= 5;
					else ivl--;
				end else if (menu == MENU_MOVE && mv > 300) begin
					mv -= 100;
				end
			end
			BTN_INC: begin
				if (menu == MENU_COUNT && tgt < 999 - 30) begin
					if (tgt >= 60) tgt += 30;
					else if (tgt >= 20) tgt += 10;
					else tgt++;
				end else if (menu == MENU_INTERVAL && ivl < 999 - 10) begin
					if (ivl >= 60) ivl += 10;
					else if (ivl >= 20) ivl += 5;
					else ivl++;
				end else if (menu == MENU_MOVE && mv < 900) begin
					mv += 100;
				end
			end
			default: begin
				if (menu < MENU_SHOOT) begin
					menu++;
					if (menu == MENU_SHOOT) secc = 0;
				end
			end
		endcase
	endfunction

	function automatic void apply_tick();
		bit new_sec;
		new_sec = 1'b0;
		msc = (msc + 1) & 'h3FF;
		if (msc >= tps || msc == 0) begin
			msc = 0;
			secc = (secc + 1) & 'hFF;
			new_sec = 1'b1;
		end
		if (ph != PH_IDLE) begin
			ptmr = (ptmr - 1) & 'hFFFF;
			if (ptmr == 0)
				enter_phase(ph >= PH_WAIT ? PH_IDLE : ph + 1);
		end
		if (ph == PH_IDLE && menu == MENU_SHOOT && sec_mod() == 0 && taken < tgt)
			enter_phase(ivl > wake_thr ? PH_WAKE : PH_FOCUS);
		if (new_sec)
			refresh_display();
	endfunction

	function automatic result_t controller_step(bit m, button_t b);
		result_t r;
		if (!m)
			apply_tick();
		else if (ph == PH_IDLE)
			apply_press(b);
		r.focus_on = (ph == PH_WAKE || ph == PH_FOCUS || ph == PH_SHUT);
		r.shutter_on = (ph == PH_SHUT);
		r.motor_on = (ph == PH_MOTOR);
		r.menu_position = menu[1:0];
		r.shot_target = tgt[9:0];
		r.interval_s = ivl[9:0];
		r.move_ms = mv[9:0];
		r.shots_done = taken[9:0];
		r.left_hours = hms[16:12];
		r.left_minutes = hms[11:6];
		r.left_seconds = hms[5:0];
		r.next_shot_in = cdown[9:0];
		return r;
	endfunction

	task automatic send(bit m, button_t b);
		in_valid <= 1'b1;
		mode <= m;
		button <= b;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
	endtask

	task automatic gap();
		if (!calm && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 15)) @(posedge clk);
		end
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (exp_q.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, int unsigned val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val[CFG_DATA_W-1:0];
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			CFG_EXPOSURE: expo = val & 'hFFFF;
			CFG_WAKE: wake_thr = val & 'hFF;
			default: tps = val & 'h3FF;
		endcase
	endtask

	task automatic set_timing(int unsigned e, int unsigned w, int unsigned t);
		drain();
		repeat (200) @(posedge clk);
		write_cfg(CFG_EXPOSURE, e);
		write_cfg(CFG_WAKE, w);
		write_cfg(CFG_TPS, t);
	endtask

	task automatic random_beats(int n, bit pause_mid, bit hold_mid);
		int r;
		bit m;
		button_t b;
		for (int i = 0; i < n; i++) begin
			if (hold_mid && i == n / 3)
				hold_req = 1'b1;
			if (pause_mid && i == n / 2)
				drain();
			r = $urandom_range(0, 99);
			b = button_t'($urandom_range(0, 3));
			m = (menu == MENU_SHOOT) ? (r >= 90) : (r >= 30);
			if (m && menu != MENU_SHOOT) begin
				r = $urandom_range(0, 99);
				b = (r < 30) ? BTN_NEXT : (r < 60) ? BTN_INC : (r < 85) ? BTN_DEC : BTN_PREV;
			end
			send(m, b);
			exp_q.push_back(controller_step(m, b));
			gap();
		end
	endtask

	task automatic check_field(string name, int unsigned e, int unsigned a);
		if (e != a) begin
			$display("%0t: %s mismatch, expected %0d, got %0d", $time, name, e, a);
			errs++;
		end
	endtask

	always @(posedge clk) begin
		result_t e;
		if (arst_n && out_valid && !out_stall) begin
			if (exp_q.size() == 0) begin
				$display("%0t: unexpected beat, expected none, got menu %0d", $time,
					menu_position);
				errs++;
			end else begin
				e = exp_q.pop_front();
				check_field("focus_on", e.focus_on, focus_on);
				check_field("shutter_on", e.shutter_on, shutter_on);
				check_field("motor_on", e.motor_on, motor_on);
				check_field("menu_position", e.menu_position, menu_position);
				check_field("shot_target", e.shot_target, shot_target);
				check_field("interval_s", e.interval_s, interval_s);
				check_field("move_ms", e.move_ms, move_ms);
				check_field("shots_done", e.shots_done, shots_done);
				check_field("left_hours", e.left_hours, left_hours);
				check_field("left_minutes", e.left_minutes, left_minutes);
				check_field("left_seconds", e.left_seconds, left_seconds);
				check_field("next_shot_in", e.next_shot_in, next_shot_in);
			end
		end
	end

	initial begin
		@(posedge arst_n);
		forever begin
			if (hold_req) begin
				hold_req = 1'b0;
				out_stall <= 1'b1;
				repeat (300) @(posedge clk);
			end else if (!calm && $urandom_range(0, 2) == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 15)) @(posedge clk);
			end else begin
				out_stall <= 1'b0;
				repeat ($urandom_range(1, 20)) @(posedge clk);
			end
		end
	end

	initial begin
		#30ms;
		$display("tb_slider_intervalometer_controller failed");
		$finish;
	end

	initial begin
		stim_row_t rows[$];
		result_t r;
		rows = '{
			'{1, BTN_PREV, 1, MENU_COUNT, 60, 20, 300},
			'{1, BTN_DEC, 1, MENU_COUNT, 50, 20, 300},
			'{1, BTN_INC, 1, MENU_COUNT, 60, 20, 300},
			'{1, BTN_INC, 1, MENU_COUNT, 90, 20, 300},
			'{1, BTN_DEC, 1, MENU_COUNT, 60, 20, 300},
			'{1, BTN_INC, 1, MENU_COUNT, 90, 20, 300},
			'{1, BTN_NEXT, 1, MENU_INTERVAL, 90, 20, 300},
			'{1, BTN_DEC, 1, MENU_INTERVAL, 90, 19, 300},
			'{1, BTN_INC, 1, MENU_INTERVAL, 90, 20, 300},
			'{1, BTN_INC, 1, MENU_INTERVAL, 90, 25, 300},
			'{1, BTN_NEXT, 1, MENU_MOVE, 90, 25, 300},
			'{1, BTN_DEC, 1, MENU_MOVE, 90, 25, 300},
			'{1, BTN_INC, 1, MENU_MOVE, 90, 25, 400},
			'{1, BTN_NEXT, 1, MENU_SHOOT, 90, 25, 400},
			'{1, BTN_INC, 1, MENU_SHOOT, 90, 25, 400},
			'{1, BTN_NEXT, 1, MENU_SHOOT, 90, 25, 400},
			'{0, BTN_NEXT, 0, MENU_SHOOT, 0, 0, 0},
			'{1, BTN_PREV, 1, MENU_SHOOT, 90, 25, 400},
			'{0, BTN_INC, 0, MENU_SHOOT, 0, 0, 0},
			'{0, BTN_PREV, 0, MENU_SHOOT, 0, 0, 0},
			'{0, BTN_DEC, 0, MENU_SHOOT, 0, 0, 0}
		};
		expo = 100; wake_thr = 60; tps = 1000;
		menu = MENU_COUNT; tgt = 60; ivl = 20; mv = 300;
		taken = 0; msc = 0; secc = 0; ph = PH_IDLE; ptmr = 0; hms = 0; cdown = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (rows[i]) begin
			send(rows[i].m, rows[i].b);
			r = controller_step(rows[i].m, rows[i].b);
			if (rows[i].chk) begin
				r.menu_position = rows[i].menu;
				r.shot_target = rows[i].tgt;
				r.interval_s = rows[i].ivl;
				r.move_ms = rows[i].mv;
			end
			exp_q.push_back(r);
			gap();
		end
		set_timing(1, 0, 1);
		random_beats(400, 0, 1);
		set_timing(65535, 255, 1023);
		random_beats(300, 1, 0);
		set_timing(7, 30, 0);
		random_beats(400, 0, 0);
		set_timing($urandom_range(1, 300), $urandom_range(0, 255), $urandom_range(1, 4));
		random_beats(400, 1, 1);
		set_timing(3, 255, 2);
		calm = 1'b1;
		random_beats(400, 0, 0);
		drain();
		repeat (200) @(posedge clk);
		if (errs == 0)
			$display("tb_slider_intervalometer_controller passed");
		else
			$display("tb_slider_intervalometer_controller failed");
		$finish;
	end
endmodule
